>>> hw/rtl/dpsp_pkg.sv
// Package with the shared types, constants and helpers of the power-state policy block.
`default_nettype none

package dpsp_pkg;

  // Depth of the idle-duration history window.
  localparam int unsigned HIST_DEPTH = 3;

  // Width of one serial multiplier pass and of its step counter.
  localparam int unsigned MUL_W = 16;
  localparam int unsigned CNT_W = $clog2(MUL_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_W - 1);

  // Width of the prediction accumulator; holds any Q.8 prediction exactly.
  localparam int unsigned PW = 50;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_IDLE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_SLEEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SQUARE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LINEAR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_CONST     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_IDLE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_SLEEP = 3'd7;

  // Item commands.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Policy selection.
  localparam logic POLICY_TIMEOUT    = 1'b0;
  localparam logic POLICY_PREDICTIVE = 1'b1;

  // Decided power state.
  typedef enum logic [1:0] {
    PS_ACTIVE = 2'd0,
    PS_IDLE   = 2'd1,
    PS_SLEEP  = 2'd2
  } pstate_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    F_IDLE,
    F_SQ,
    F_MSQ,
    F_MLIN,
    F_FIN
  } fsm_e;

  // Saturating increment of a 32-bit counter.
  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dpsp_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none

interface dpsp_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] idle_start;
  logic [31:0] idle_end;

  modport source (output valid, command, idle_start, idle_end, input ready);
  modport sink   (input valid, command, idle_start, idle_end, output ready);
endinterface

interface dpsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  power_state;
  logic [31:0] tick_time;
  logic        state_changed;
  logic [31:0] transition_total;
  logic [31:0] waiting_ticks;
  logic [31:0] active_ticks;
  logic [31:0] idle_ticks;
  logic [31:0] sleep_ticks;
  logic        period_over;
  logic        rejected;

  modport source (output valid, power_state, tick_time, state_changed, transition_total,
                  waiting_ticks, active_ticks, idle_ticks, sleep_ticks, period_over,
                  rejected, input ready);
  modport sink   (input valid, power_state, tick_time, state_changed, transition_total,
                  waiting_ticks, active_ticks, idle_ticks, sleep_ticks, period_over,
                  rejected, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dynamic_power_state_policy_core.sv
// A load or a timeout-policy tick passes through F_FIN into the output register.
// A predictive-policy tick first runs three 16-step passes of the
// bit-serial shift-add multiplier (newest^2, alpha_square term, alpha_linear term).
// F_FIN waits while a result is pending. Items are taken one at a time, again as soon
// as the sequencer is back in its idle state, even while a result waits in the output register.
// Reset: asynchronous active low; clears all configuration, policy state and counters.
`default_nettype none

module dynamic_power_state_policy_core import dpsp_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [31:0]          cfg_wdata_i,
  dpsp_in_if.sink             item_in,
  dpsp_out_if.source          result_out
);

  // Configuration registers.
  logic        policy_q;
  logic [15:0] timeout_idle_q;
  logic [15:0] timeout_sleep_q;
  logic [15:0] alpha_square_q;
  logic [15:0] alpha_linear_q;
  logic [31:0] alpha_const_q;
  logic [15:0] threshold_idle_q;
  logic [15:0] threshold_sleep_q;

  // Policy state.
  logic [31:0] tick_q, tick_d;
  logic [31:0] pstart_q, pstart_d;
  logic [31:0] pend_q, pend_d;
  logic [15:0] hist_q [HIST_DEPTH];
  logic [15:0] hist_d [HIST_DEPTH];
  pstate_e     prev_q, prev_d;
  logic [31:0] trans_q, trans_d;
  logic [31:0] wait_q, wait_d;
  logic [31:0] act_q, act_d;
  logic [31:0] idl_q, idl_d;
  logic [31:0] slp_q, slp_d;

  // Sequencer and serial multiplier.
  fsm_e             fsm_q, fsm_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PW-1:0]    acc_q, acc_d;
  logic [PW-1:0]    mc_q, mc_d;
  logic [MUL_W-1:0] mul_q, mul_d;

  // Latched input item.
  logic        cmd_q, cmd_d;
  logic [31:0] start_q, start_d;
  logic [31:0] end_q, end_d;

  // Output register.
  logic        ov_q, ov_d;
  pstate_e     o_state_q, o_state_d;
  logic [31:0] o_tick_q, o_tick_d;
  logic        o_changed_q, o_changed_d;
  logic        o_over_q, o_over_d;
  logic        o_rej_q, o_rej_d;

  // Combinational helpers.
  logic [PW-1:0] addend;
  logic [PW-1:0] step_sum;
  logic          step_last;
  logic          rej;
  logic [31:0]   diff;
  logic [15:0]   dur;
  logic [32:0]   lim_idle;
  logic [32:0]   lim_sleep;
  logic [PW-1:0] th_idle;
  logic [PW-1:0] th_sleep;
  pstate_e       decided;
  logic          slot_free;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q          <= POLICY_TIMEOUT;
      timeout_idle_q    <= '0;
      timeout_sleep_q   <= '0;
      alpha_square_q    <= '0;
      alpha_linear_q    <= '0;
      alpha_const_q     <= '0;
      threshold_idle_q  <= '0;
      threshold_sleep_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POLICY:          policy_q          <= cfg_wdata_i[0];
        REG_TIMEOUT_IDLE:    timeout_idle_q    <= cfg_wdata_i[15:0];
        REG_TIMEOUT_SLEEP:   timeout_sleep_q   <= cfg_wdata_i[15:0];
        REG_ALPHA_SQUARE:    alpha_square_q    <= cfg_wdata_i[15:0];
        REG_ALPHA_LINEAR:    alpha_linear_q    <= cfg_wdata_i[15:0];
        REG_ALPHA_CONST:     alpha_const_q     <= cfg_wdata_i;
        REG_THRESHOLD_IDLE:  threshold_idle_q  <= cfg_wdata_i[15:0];
        REG_THRESHOLD_SLEEP: threshold_sleep_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // One shift-add step: the multiplier's low bit selects the shifted multiplicand.
  // The top bit of alpha_square carries negative weight, so its step subtracts.
  assign addend    = mul_q[0] ? mc_q : '0;
  assign step_last = (cnt_q == CNT_LAST);
  assign step_sum  = (fsm_q == F_MSQ && step_last) ? acc_q - addend : acc_q + addend;

  // Rejection and the new history entry.
  assign diff = end_q - start_q;
  assign dur  = (diff[31:16] != 16'd0) ? 16'hFFFF : diff[15:0];
  assign rej  = (cmd_q == CMD_LOAD) ? (end_q < start_q) : (tick_q >= pend_q);

  // Timeout limits and prediction thresholds.
  assign lim_idle  = {1'b0, pstart_q} + {17'd0, timeout_idle_q};
  assign lim_sleep = {1'b0, pstart_q} + {17'd0, timeout_sleep_q};
  assign th_idle   = PW'({threshold_idle_q, 8'h00});
  assign th_sleep  = PW'({threshold_sleep_q, 8'h00});

  // State decision for the current tick.
  always_comb begin
    decided = PS_ACTIVE;
    if (policy_q == POLICY_TIMEOUT) begin
      if ({1'b0, tick_q} > lim_idle) begin
        decided = PS_IDLE;
        if (timeout_sleep_q > timeout_idle_q && {1'b0, tick_q} > lim_sleep) begin
          decided = PS_SLEEP;
        end
      end
    end else if (tick_q >= pstart_q) begin
      if ($signed(acc_q) >= $signed(th_idle)) begin
        decided = PS_IDLE;
        if ($signed(acc_q) >= $signed(th_sleep) && threshold_sleep_q > threshold_idle_q) begin
          decided = PS_SLEEP;
        end
      end
    end
  end

  assign slot_free     = !ov_q || result_out.ready;
  assign item_in.ready = (fsm_q == F_IDLE);

  // Sequencer: next state, serial datapath and state update.
  always_comb begin
    fsm_d       = fsm_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    mc_d        = mc_q;
    mul_d       = mul_q;
    cmd_d       = cmd_q;
    start_d     = start_q;
    end_d       = end_q;
    tick_d      = tick_q;
    pstart_d    = pstart_q;
    pend_d      = pend_q;
    hist_d      = hist_q;
    prev_d      = prev_q;
    trans_d     = trans_q;
    wait_d      = wait_q;
    act_d       = act_q;
    idl_d       = idl_q;
    slp_d       = slp_q;
    ov_d        = ov_q && !result_out.ready;
    o_state_d   = o_state_q;
    o_tick_d    = o_tick_q;
    o_changed_d = o_changed_q;
    o_over_d    = o_over_q;
    o_rej_d     = o_rej_q;

    case (fsm_q)
      F_IDLE: begin
        if (item_in.valid) begin
          cmd_d   = item_in.command;
          start_d = item_in.idle_start;
          end_d   = item_in.idle_end;
          if (item_in.command == CMD_TICK && policy_q == POLICY_PREDICTIVE) begin
            fsm_d = F_SQ;
            cnt_d = '0;
            acc_d = '0;
            mc_d  = PW'(hist_q[HIST_DEPTH-1]);
            mul_d = hist_q[HIST_DEPTH-1];
          end else begin
            fsm_d = F_FIN;
          end
        end
      end
      F_SQ, F_MSQ, F_MLIN: begin
        acc_d = step_sum;
        mc_d  = mc_q << 1;
        mul_d = mul_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (step_last) begin
          case (fsm_q)
            F_SQ: begin
              // Square done: it becomes the multiplicand, the constant seeds the sum.
              fsm_d = F_MSQ;
              mc_d  = PW'(step_sum[31:0]);
              mul_d = alpha_square_q;
              acc_d = {{(PW-32){alpha_const_q[31]}}, alpha_const_q};
            end
            F_MSQ: begin
              fsm_d = F_MLIN;
              mc_d  = {{(PW-16){alpha_linear_q[15]}}, alpha_linear_q};
              mul_d = hist_q[HIST_DEPTH-2];
            end
            default: begin
              fsm_d = F_FIN;
            end
          endcase
        end
      end
      F_FIN: begin
        if (slot_free) begin
          fsm_d       = F_IDLE;
          ov_d        = 1'b1;
          o_state_d   = prev_q;
          o_tick_d    = tick_q;
          o_changed_d = 1'b0;
          o_over_d    = 1'b0;
          o_rej_d     = rej;
          if (!rej) begin
            if (cmd_q == CMD_LOAD) begin
              // Store the period and shift its duration into the history.
              pstart_d = start_q;
              pend_d   = end_q;
              for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                hist_d[i] = hist_q[i+1];
              end
              hist_d[HIST_DEPTH-1] = dur;
            end else begin
              o_state_d = decided;
              if (decided != prev_q) begin
                o_changed_d = 1'b1;
                trans_d     = sat_inc32(trans_q);
              end
              case (decided)
                PS_ACTIVE: act_d = sat_inc32(act_q);
                PS_IDLE:   idl_d = sat_inc32(idl_q);
                PS_SLEEP:  slp_d = sat_inc32(slp_q);
                default: ;
              endcase
              if (decided == PS_ACTIVE && tick_q >= pstart_q) begin
                wait_d = sat_inc32(wait_q);
              end
              prev_d   = decided;
              tick_d   = tick_q + 32'd1;
              o_over_d = ((tick_q + 32'd1) == pend_q);
            end
          end
        end
      end
      default: begin
        fsm_d = F_IDLE;
      end
    endcase
  end

  // Control and policy state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q    <= F_IDLE;
      cnt_q    <= '0;
      ov_q     <= 1'b0;
      tick_q   <= '0;
      pstart_q <= '0;
      pend_q   <= '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
      prev_q   <= PS_ACTIVE;
      trans_q  <= '0;
      wait_q   <= '0;
      act_q    <= '0;
      idl_q    <= '0;
      slp_q    <= '0;
    end else begin
      fsm_q    <= fsm_d;
      cnt_q    <= cnt_d;
      ov_q     <= ov_d;
      tick_q   <= tick_d;
      pstart_q <= pstart_d;
      pend_q   <= pend_d;
      hist_q   <= hist_d;
      prev_q   <= prev_d;
      trans_q  <= trans_d;
      wait_q   <= wait_d;
      act_q    <= act_d;
      idl_q    <= idl_d;
      slp_q    <= slp_d;
    end
  end

  // Payload registers of the datapath and the output.
  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    mc_q        <= mc_d;
    mul_q       <= mul_d;
    cmd_q       <= cmd_d;
    start_q     <= start_d;
    end_q       <= end_d;
    o_state_q   <= o_state_d;
    o_tick_q    <= o_tick_d;
    o_changed_q <= o_changed_d;
    o_over_q    <= o_over_d;
    o_rej_q     <= o_rej_d;
  end

  // Result channel.
  assign result_out.valid            = ov_q;
  assign result_out.power_state      = o_state_q;
  assign result_out.tick_time        = o_tick_q;
  assign result_out.state_changed    = o_changed_q;
  assign result_out.transition_total = trans_q;
  assign result_out.waiting_ticks    = wait_q;
  assign result_out.active_ticks     = act_q;
  assign result_out.idle_ticks       = idl_q;
  assign result_out.sleep_ticks      = slp_q;
  assign result_out.period_over      = o_over_q;
  assign result_out.rejected         = o_rej_q;

  // The transition count never goes backward.
  a_trans_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q != F_IDLE) |=> (trans_q >= $past(trans_q)))
    else $error("transition count decreased");

  // A pending result blocks the final step until it is taken.
  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == F_FIN && ov_q && !result_out.ready) |=> (fsm_q == F_FIN && ov_q))
    else $error("result written over a pending result");

  // The square pass hands over to the alpha_square pass after its last step.
  a_sq_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == F_SQ && step_last) |=> (fsm_q == F_MSQ && cnt_q == '0))
    else $error("serial pass sequencing broken");

  // The tick only advances on a finished, accepted tick transaction.
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_q != $past(tick_q)) |-> ($past(fsm_q) == F_FIN && $past(cmd_q) == CMD_TICK))
    else $error("tick advanced outside a tick transaction");

endmodule

`default_nettype wire
